// ===== src/display_name_to_fat83_top_macros.svh =====
// assertion macros shared by the fat 8.3 name converter modules
// expects clk and arst_n in the scope where a macro is used
`ifndef DISPLAY_NAME_TO_FAT83_TOP_MACROS_SVH
`define DISPLAY_NAME_TO_FAT83_TOP_MACROS_SVH

// same-cycle implication, disabled during reset
`define DN83_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("dn83 assertion failed");

// next-cycle implication, disabled during reset
`define DN83_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dn83 assertion failed");

`endif

// ===== src/dn83_pkg.sv =====
// shared types, constants and helpers for the fat 8.3 name converter
// no dependencies
`default_nettype none

package dn83_pkg;

	localparam int BASE_CHARS = 8;
	localparam int EXT_CHARS  = 3;
	localparam int NAME_BYTES = BASE_CHARS + EXT_CHARS;

	localparam logic [3:0] LAST_POS      = 4'(NAME_BYTES - 1);
	localparam logic [3:0] BASE_LEN_FULL = 4'(BASE_CHARS);

	localparam logic [7:0] CH_NUL     = 8'h00;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_DOT     = 8'h2e;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7a;
	localparam logic [7:0] CASE_DELTA = 8'h20;

	// parse phase codes
	localparam logic [2:0] PH_FIRST   = 3'd0;
	localparam logic [2:0] PH_DOT1    = 3'd1;
	localparam logic [2:0] PH_BASE    = 3'd2;
	localparam logic [2:0] PH_DOTSKIP = 3'd3;
	localparam logic [2:0] PH_EXT     = 3'd4;
	localparam logic [2:0] PH_IGNORE  = 3'd5;

	typedef logic [NAME_BYTES-1:0][7:0] name_t;

	typedef struct packed {
		logic  valid;
		name_t name;
	} name_xfer_t;

	localparam name_t BLANK_NAME = {NAME_BYTES{CH_SPACE}};

	function automatic logic [7:0] to_upper(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b inside {[CH_LOWER_A:CH_LOWER_Z]})
			r = b - CASE_DELTA;
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== src/dn83_front.sv =====
// front end: parses one name character per transaction into the 11-byte buffer
// uses dn83_pkg; hands finished names to dn83_queue
`default_nettype none

module dn83_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           name_char,
	input  logic                 name_end,
	output dn83_pkg::name_xfer_t push,
	input  logic                 q_full
);
	import dn83_pkg::*;
	`include "display_name_to_fat83_top_macros.svh"

	logic [2:0] phase_q;
	logic [3:0] base_len_q;
	logic [1:0] ext_len_q;
	name_t      buf_q;

	logic [2:0] nxt_phase;
	logic [3:0] nxt_base;
	logic [1:0] nxt_ext;
	name_t      nxt_buf;
	logic       wr_en;
	logic [3:0] wr_idx;
	logic       base_put;
	logic       ext_put;
	logic       is_nul;
	logic       is_dot;
	logic       accept;

	assign is_nul   = (name_char == CH_NUL);
	assign is_dot   = (name_char == CH_DOT);
	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		nxt_phase = phase_q;
		nxt_base  = base_len_q;
		nxt_ext   = ext_len_q;
		wr_en     = 1'b0;
		wr_idx    = 4'd0;
		base_put  = 1'b0;
		ext_put   = 1'b0;
		case (phase_q)
			PH_FIRST: begin
				if (is_nul) begin
					nxt_phase = PH_IGNORE;
				end else if (is_dot) begin
					wr_en     = 1'b1;
					wr_idx    = 4'd0;
					nxt_phase = PH_DOT1;
				end else begin
					base_put = 1'b1;
				end
			end
			PH_DOT1: begin
				if (is_dot) begin
					wr_en  = 1'b1;
					wr_idx = 4'd1;
				end
				nxt_phase = PH_IGNORE;
			end
			PH_BASE: begin
				if (is_nul)
					nxt_phase = PH_IGNORE;
				else if (is_dot)
					nxt_phase = PH_EXT;
				else
					base_put = 1'b1;
			end
			PH_DOTSKIP: begin
				if (is_nul)
					nxt_phase = PH_IGNORE;
				else if (is_dot)
					nxt_phase = PH_EXT;
				else
					ext_put = 1'b1;
			end
			PH_EXT: begin
				if (is_nul)
					nxt_phase = PH_IGNORE;
				else
					ext_put = 1'b1;
			end
			default: begin
				nxt_phase = PH_IGNORE;
			end
		endcase

		if (base_put) begin
			if (base_len_q < BASE_LEN_FULL) begin
				wr_en    = 1'b1;
				wr_idx   = base_len_q;
				nxt_base = base_len_q + 4'd1;
			end
			nxt_phase = (nxt_base >= BASE_LEN_FULL) ? PH_DOTSKIP : PH_BASE;
		end

		if (ext_put) begin
			if (ext_len_q < 2'(EXT_CHARS)) begin
				wr_en   = 1'b1;
				wr_idx  = BASE_LEN_FULL + {2'b00, ext_len_q};
				nxt_ext = ext_len_q + 2'd1;
			end
			nxt_phase = (ext_len_q >= 2'(EXT_CHARS - 1)) ? PH_IGNORE : PH_EXT;
		end

		nxt_buf = buf_q;
		for (int k = 0; k < NAME_BYTES; k++) begin
			if (wr_en && (wr_idx == 4'(k)))
				nxt_buf[k] = name_char;
		end
	end

	assign push.valid = accept && name_end;
	assign push.name  = nxt_buf;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FIRST;
			base_len_q <= 4'd0;
			ext_len_q  <= 2'd0;
			buf_q      <= BLANK_NAME;
		end else if (accept) begin
			if (name_end) begin
				phase_q    <= PH_FIRST;
				base_len_q <= 4'd0;
				ext_len_q  <= 2'd0;
				buf_q      <= BLANK_NAME;
			end else begin
				phase_q    <= nxt_phase;
				base_len_q <= nxt_base;
				ext_len_q  <= nxt_ext;
				buf_q      <= nxt_buf;
			end
		end
	end

	`DN83_ASSERT_IMP(a_dotskip_base_full, phase_q == PH_DOTSKIP, base_len_q == BASE_LEN_FULL)
	`DN83_ASSERT_IMP(a_base_partial, phase_q == PH_BASE,
		(base_len_q != 4'd0) && (base_len_q < BASE_LEN_FULL))

endmodule

`default_nettype wire

// ===== src/dn83_queue.sv =====
// short queue of finished 11-byte names between front and back
// uses dn83_pkg
`default_nettype none

module dn83_queue #(
	parameter int DEPTH = 2
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dn83_pkg::name_xfer_t push,
	output logic                 full,
	output dn83_pkg::name_xfer_t head,
	input  logic                 pop
);
	import dn83_pkg::*;
	`include "display_name_to_fat83_top_macros.svh"

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	name_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head.valid = (count_q != '0);
	assign head.name  = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push.name;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	`DN83_ASSERT_IMP(a_no_push_when_full, push.valid, !full)
	`DN83_ASSERT_IMP(a_no_pop_when_empty, pop, head.valid)

endmodule

`default_nettype wire

// ===== src/dn83_back.sv =====
// back end: serializes one queued name into 11 uppercased byte transactions
// uses dn83_pkg; takes names from dn83_queue
`default_nettype none

module dn83_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dn83_pkg::name_xfer_t head,
	output logic                 pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [7:0]           out_char,
	output logic [3:0]           out_position,
	output logic                 out_last
);
	import dn83_pkg::*;
	`include "display_name_to_fat83_top_macros.svh"

	logic       valid_q;
	logic [3:0] pos_q;
	name_t      name_q;
	logic       take;
	logic       at_last;

	assign take    = valid_q && !out_stall;
	assign at_last = (pos_q == LAST_POS);
	assign pop     = head.valid && (!valid_q || (take && at_last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= 4'd0;
		end else if (pop) begin
			valid_q <= 1'b1;
			pos_q   <= 4'd0;
		end else if (take) begin
			if (at_last)
				valid_q <= 1'b0;
			else
				pos_q <= pos_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			name_q <= head.name;
	end

	assign out_valid    = valid_q;
	assign out_char     = to_upper(name_q[pos_q]);
	assign out_position = pos_q;
	assign out_last     = at_last;

	`DN83_ASSERT_IMP(a_pos_in_range, valid_q, pos_q <= LAST_POS)
	`DN83_ASSERT_NXT(a_drain_goes_idle, take && at_last && !head.valid, !valid_q)

endmodule

`default_nettype wire

// ===== src/display_name_to_fat83_top.sv =====
// top level of the fat 8.3 short name converter
// uses dn83_pkg, dn83_front, dn83_queue, dn83_back
`default_nettype none

// The block takes a file name one character per input transaction (name_char,
// with name_end set on the last character) and, for each name, delivers the
// 11-byte space-padded 8.3 directory entry name as 11 output transactions,
// positions 0 to 10, with a-z uppercased and out_last on position 10. The
// front parser accepts one character every cycle unless in_stall is high; a
// name's result goes into a queue of NAME_QUEUE_DEPTH finished names, so the
// parser runs straight on into the next name while the back serializer sends
// the 11 bytes, one per cycle when out_stall is low. in_stall rises only while
// that queue is full. A leading "." or ".." gives that name, a zero byte ends
// a name, characters after a full 8-byte base go into the extension, and
// characters beyond 3 extension bytes are dropped.

module display_name_to_fat83_top #(
	parameter int NAME_QUEUE_DEPTH = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	// character input channel
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] name_char,
	input  logic       name_end,
	// 8.3 name byte output channel
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_char,
	output logic [3:0] out_position,
	output logic       out_last
);
	import dn83_pkg::*;

	// finished name from the parser, and the oldest waiting name
	name_xfer_t push;
	name_xfer_t head;
	logic       q_full;
	logic       pop;

	// parser: phase tracking, base and extension counts, name buffer
	dn83_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.name_char (name_char),
		.name_end  (name_end),
		.push      (push),
		.q_full    (q_full)
	);

	// decouples parsing from byte output
	dn83_queue #(
		.DEPTH (NAME_QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	// serializer: one uppercased byte per output transaction
	dn83_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_char     (out_char),
		.out_position (out_position),
		.out_last     (out_last)
	);

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for display_name_to_fat83_top, the fat 8.3 short name builder
// depends on dn83_pkg for the phase codes, character constants and name sizes
// holds its own name predictor, directed and random names, bursty input and stalling output

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import dn83_pkg::*;

	// one byte of a finished 8.3 name as the output channel carries it
	typedef struct {
		logic [7:0] ch;
		logic [3:0] pos;
		logic       last;
	} name_byte_t;

	// tracks the parse of the current name and keeps the bytes still owed by the block
	class short_name_predictor;
		logic [7:0] entry [NAME_BYTES];
		logic [2:0] phase;
		int         base_len;
		int         ext_len;
		int         mismatches;
		name_byte_t expected_bytes [$];

		function new();
			mismatches = 0;
			clear();
		endfunction

		function void clear();
			foreach (entry[k])
				entry[k] = CH_SPACE;
			phase    = PH_FIRST;
			base_len = 0;
			ext_len  = 0;
		endfunction

		function void put_base(input logic [7:0] c);
			if (base_len < BASE_CHARS) begin
				entry[base_len] = c;
				base_len++;
			end
			phase = (base_len >= BASE_CHARS) ? PH_DOTSKIP : PH_BASE;
		endfunction

		function void put_ext(input logic [7:0] c);
			if (ext_len < EXT_CHARS) begin
				entry[BASE_CHARS + ext_len] = c;
				ext_len++;
			end
			phase = (ext_len >= EXT_CHARS) ? PH_IGNORE : PH_EXT;
		endfunction

		// note one accepted input transaction; on the last character queue all 11 bytes
		function void take_char(input logic [7:0] c, input logic last);
			logic [7:0] b;
			name_byte_t nb;
			case (phase)
				PH_FIRST: begin
					if (c == CH_NUL)
						phase = PH_IGNORE;
					else if (c == CH_DOT) begin
						entry[0] = CH_DOT;
						phase = PH_DOT1;
					end else
						put_base(c);
				end
				PH_DOT1: begin
					if (c == CH_DOT)
						entry[1] = CH_DOT;
					phase = PH_IGNORE;
				end
				PH_BASE: begin
					if (c == CH_NUL)
						phase = PH_IGNORE;
					else if (c == CH_DOT)
						phase = PH_EXT;
					else
						put_base(c);
				end
				PH_DOTSKIP: begin
					if (c == CH_NUL)
						phase = PH_IGNORE;
					else if (c == CH_DOT)
						phase = PH_EXT;
					else
						put_ext(c);
				end
				PH_EXT: begin
					if (c == CH_NUL)
						phase = PH_IGNORE;
					else
						put_ext(c);
				end
				default: phase = PH_IGNORE;
			endcase
			if (last) begin
				for (int k = 0; k < NAME_BYTES; k++) begin
					b = entry[k];
					if (b >= CH_LOWER_A && b <= CH_LOWER_Z)
						b = b - CASE_DELTA;
					nb.ch   = b;
					nb.pos  = 4'(k);
					nb.last = (4'(k) == LAST_POS);
					expected_bytes.push_back(nb);
				end
				clear();
			end
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		// compare one accepted output transaction with the oldest byte owed
		function void check_byte(input logic [7:0] c, input logic [3:0] p, input logic l);
			name_byte_t want;
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 30)
					$display("%0t: unexpected name byte, expected none, got char %h pos %0d last %b",
						$time, c, p, l);
				return;
			end
			want = expected_bytes.pop_front();
			if (c !== want.ch) begin
				mismatches++;
				if (mismatches <= 30)
					$display("%0t: out_char expected %h got %h", $time, want.ch, c);
			end
			if (p !== want.pos) begin
				mismatches++;
				if (mismatches <= 30)
					$display("%0t: out_position expected %0d got %0d", $time, want.pos, p);
			end
			if (l !== want.last) begin
				mismatches++;
				if (mismatches <= 30)
					$display("%0t: out_last expected %b got %b", $time, want.last, l);
			end
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] name_char;
	logic       name_end;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_char;
	logic [3:0] out_position;
	logic       out_last;

	short_name_predictor pred = new();

	// characters of the name about to be sent
	logic [7:0] name_q [$];

	// sender burst bookkeeping
	int burst_left = 0;

	// long receiver hold-off, asked for by the stimulus and served by the receiver
	int holds_asked = 0;
	int holds_done  = 0;
	int hold_left   = 0;
	logic [31:0] rx_cycle = 0;

	display_name_to_fat83_top dut (.*);

	// 12 ns clock
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#3ms;
		$display("simulation failed");
		$finish;
	end

	// receiver: check every accepted byte, then pick the next stall value
	// the pattern steps through no stall, light, heavy and alternating stall, chosen by bits 7:6 of rx_cycle
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			pred.check_byte(out_char, out_position, out_last);
		rx_cycle <= rx_cycle + 1;
		if (hold_left > 0) begin
			// long hold-off in progress, the block has to back up into its input
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
			if (hold_left == 0)
				holds_done = holds_done + 1;
		end else if (holds_done != holds_asked) begin
			hold_left = 80;
			out_stall <= 1'b1;
		end else begin
			case (rx_cycle[7:6])
				2'd0: out_stall <= 1'b0;
				2'd1: out_stall <= ($urandom_range(0, 3) == 0);
				2'd2: out_stall <= ($urandom_range(0, 3) != 0);
				default: out_stall <= rx_cycle[0];
			endcase
		end
	end

	// offer one character and wait for the transaction; opens a random gap when a burst ends
	task automatic send_char(input logic [7:0] c, input logic e);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			// mostly short bursts, now and then a long unbroken stretch
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 8);
		end
		burst_left--;
		in_valid  <= 1'b1;
		name_char <= c;
		name_end  <= e;
		do
			@(posedge clk);
		while (in_stall);
		pred.take_char(c, e);
	endtask

	// send the characters in name_q with name_end on the last one
	task automatic send_name();
		for (int k = 0; k < name_q.size(); k++)
			send_char(name_q[k], k == name_q.size() - 1);
	endtask

	// sender goes idle until every owed byte has come out
	task automatic wait_for_drain();
		int n;
		n = 0;
		in_valid <= 1'b0;
		while (pred.pending() != 0 && n < 20000) begin
			@(posedge clk);
			n++;
		end
		if (pred.pending() != 0) begin
			pred.mismatches++;
			$display("%0t: %0d name bytes expected but never delivered", $time, pred.pending());
		end
	endtask

	// a plausible file name character: either case letter, digit or any nonzero byte other than a dot
	function automatic logic [7:0] pick_name_char();
		logic [7:0] r;
		case ($urandom_range(0, 3))
			0: r = CH_LOWER_A + 8'($urandom_range(0, 25));
			1: r = CH_LOWER_A - CASE_DELTA + 8'($urandom_range(0, 25));
			2: r = 8'h30 + 8'($urandom_range(0, 9));
			default: begin
				r = 8'($urandom_range(1, 255));
				if (r == CH_DOT)
					r = 8'h5f;
			end
		endcase
		return r;
	endfunction

	// random name: mostly well formed base and extension, some leading-dot names and noise
	task automatic build_random_name();
		int kind;
		int n;
		name_q.delete();
		kind = $urandom_range(0, 9);
		if (kind < 7) begin
			// base up to 10 so that full bases spill into the extension
			n = $urandom_range(1, 10);
			repeat (n) name_q.push_back(pick_name_char());
			if ($urandom_range(0, 3) != 0) begin
				if (n < BASE_CHARS || $urandom_range(0, 1) == 1)
					name_q.push_back(CH_DOT);
				// extension of up to 4 so that a full extension drops characters
				repeat ($urandom_range(0, 4))
					name_q.push_back(($urandom_range(0, 7) == 0) ? CH_DOT : pick_name_char());
			end
			// an early zero byte with trailing junk
			if ($urandom_range(0, 7) == 0) begin
				name_q.push_back(CH_NUL);
				name_q.push_back(pick_name_char());
			end
		end else if (kind == 7) begin
			// leading dot or dot-dot followed by ignored characters
			name_q.push_back(CH_DOT);
			repeat ($urandom_range(0, 3))
				name_q.push_back(($urandom_range(0, 1) == 1) ? CH_DOT : 8'($urandom_range(0, 255)));
		end else begin
			// noise, zero bytes and dots included, possibly an empty name
			repeat ($urandom_range(1, 14)) begin
				case ($urandom_range(0, 5))
					0: name_q.push_back(CH_NUL);
					1: name_q.push_back(CH_DOT);
					default: name_q.push_back(8'($urandom_range(0, 255)));
				endcase
			end
		end
	endtask

	initial begin
		int random_chars;
		int names_sent;

		in_valid  <= 1'b0;
		name_char <= CH_NUL;
		name_end  <= 1'b0;
		arst_n    <= 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// empty name: a zero byte first gives all spaces
		name_q = '{CH_NUL};
		send_name();
		// single leading dot
		name_q = '{CH_DOT};
		send_name();
		// leading dot-dot
		name_q = '{CH_DOT, CH_DOT};
		send_name();
		// lowercase edges and their neighbors, dot ends the base, top byte value in the extension
		name_q = '{8'h61, 8'h7a, 8'h60, 8'h7b, CH_DOT, 8'hff};
		send_name();
		// full base with high bytes, next character spills into the extension
		name_q = '{8'h80, 8'h7f, 8'h41, 8'h5a, 8'h30, 8'h39, 8'h7e, 8'h01, 8'h78};
		send_name();
		// zero byte ends the name early, the rest is ignored
		name_q = '{8'h61, 8'h62, CH_NUL, 8'h63};
		send_name();
		// second dot lands in the extension as a plain character
		name_q = '{8'h61, CH_DOT, CH_DOT, 8'h62};
		send_name();

		// sender pauses until every byte of the directed names has come out
		wait_for_drain();

		// receiver holds off for a long stretch while names keep coming, filling the block
		holds_asked = holds_asked + 1;

		random_chars = 0;
		names_sent = 0;
		while (random_chars < 75) begin
			build_random_name();
			random_chars += name_q.size();
			send_name();
			names_sent++;
			if (names_sent == 6)
				wait_for_drain();
		end

		wait_for_drain();
		// let any stray byte show up before judging
		repeat (30) @(posedge clk);

		if (pred.mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/dn83_pkg.sv
src/dn83_front.sv
src/dn83_queue.sv
src/dn83_back.sv
src/display_name_to_fat83_top.sv
tb/tb.sv
